// ===== rtl/byte_range_header_parser_defines.svh =====
// Assertion macros for the byte range header parser.
`ifndef BYTE_RANGE_HEADER_PARSER_DEFINES_SVH
`define BYTE_RANGE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BRHP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/brhp_pkg.sv =====
// Shared types, constants and helpers for the byte range header parser.
package brhp_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned BoundW  = 64;
	localparam int unsigned PrefixN = 5;
	localparam int unsigned IdxW    = 3;
	localparam int unsigned OutW    = 136;

	localparam logic [ByteW-1:0] ChEq    = 8'h3D;
	localparam logic [ByteW-1:0] ChDash  = 8'h2D;
	localparam logic [ByteW-1:0] ChTab   = 8'h09;
	localparam logic [ByteW-1:0] ChSpace = 8'h20;
	localparam logic [ByteW-1:0] ChZero  = 8'h30;
	localparam logic [ByteW-1:0] ChNine  = 8'h39;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_PRE_EQ,
		PH_POST_EQ,
		PH_START_RUN,
		PH_PRE_DASH,
		PH_POST_DASH,
		PH_END_RUN
	} phase_t;

	typedef struct packed {
		logic              ok_pre;
		logic              start_present;
		logic              end_present;
		logic [BoundW-1:0] start_acc;
		logic [BoundW-1:0] end_acc;
	} final_t;

	typedef struct packed {
		logic [BoundW-1:0] acc;
		logic              ovf;
	} acc_t;

	function automatic logic [ByteW-1:0] prefix_char(input logic [IdxW-1:0] idx);
		logic [ByteW-1:0] c;
		case (idx)
			3'd0: c = 8'h62;
			3'd1: c = 8'h79;
			3'd2: c = 8'h74;
			3'd3: c = 8'h65;
			3'd4: c = 8'h73;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Multiply by ten and add the digit; flag a carry out of 64 bits.
	function automatic acc_t accumulate(input logic [BoundW-1:0] acc, input logic ovf,
			input logic [ByteW-1:0] b);
		logic [BoundW+3:0] sum;
		logic [3:0]        d;
		acc_t              r;
		d   = 4'(b - ChZero);
		sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{BoundW{1'b0}}, d};
		r.acc = acc;
		r.ovf = ovf;
		if (!ovf) begin
			if (|sum[BoundW+3:BoundW]) begin
				r.ovf = 1'b1;
			end else begin
				r.acc = sum[BoundW-1:0];
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/byte_range_header_parser.sv =====
// Top level of the byte range header parser.
// A final beat's result moves from the s1 register through s2 to the output register.
// Throughput: one byte per cycle unless a final beat is held; parse state updates per byte.
// Ready depends on m_tready, the pipeline valid bits and the held final-beat flag.
// Reset clears all valid bits and the parse state to prefix matching with zero bounds.
module byte_range_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // end-of-value mark
	input  logic         s_tuser,   // allow_spaces
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata    // parse_ok, start_present, start_value[63:0],
	                                // end_present, end_value[63:0], zero pad
);

`include "byte_range_header_parser_defines.svh"

	logic                          valid_s1;
	logic [brhp_pkg::ByteW-1:0]    byte_s1;
	logic                          last_s1;
	logic                          ws_ok_s1;

	logic                          valid_s2;
	brhp_pkg::final_t              fin_s2;

	logic                          out_valid_q;
	logic [brhp_pkg::OutW-1:0]     out_data_q;

	brhp_pkg::phase_t              phase_q, phase_d;
	logic [brhp_pkg::IdxW-1:0]     prefix_idx_q, prefix_idx_d;
	logic                          failed_q, failed_d;
	logic [brhp_pkg::BoundW-1:0]   start_acc_q, start_acc_d;
	logic                          start_seen_q, start_seen_d;
	logic                          start_ovf_q, start_ovf_d;
	logic [brhp_pkg::BoundW-1:0]   end_acc_q, end_acc_d;
	logic                          end_seen_q, end_seen_d;
	logic                          end_ovf_q, end_ovf_d;

	logic                          out_load;
	logic                          s2_free;
	logic                          adv_s1;
	logic                          digit;
	logic                          ws;
	brhp_pkg::acc_t                start_step, end_step;
	brhp_pkg::final_t              fin_d;
	logic                          ok_out;

	assign out_load = valid_s2 && (!out_valid_q || m_tready);
	assign s2_free  = !valid_s2 || out_load;
	assign adv_s1   = valid_s1 && (!last_s1 || s2_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			last_s1  <= s_tlast;
			ws_ok_s1 <= s_tuser;
		end
	end

	assign digit = (byte_s1 >= brhp_pkg::ChZero) && (byte_s1 <= brhp_pkg::ChNine);
	assign ws    = ws_ok_s1 && (byte_s1 == brhp_pkg::ChTab || byte_s1 == brhp_pkg::ChSpace);

	assign start_step = brhp_pkg::accumulate(start_acc_q, start_ovf_q, byte_s1);
	assign end_step   = brhp_pkg::accumulate(end_acc_q, end_ovf_q, byte_s1);

	always_comb begin
		phase_d      = phase_q;
		prefix_idx_d = prefix_idx_q;
		failed_d     = failed_q;
		start_acc_d  = start_acc_q;
		start_seen_d = start_seen_q;
		start_ovf_d  = start_ovf_q;
		end_acc_d    = end_acc_q;
		end_seen_d   = end_seen_q;
		end_ovf_d    = end_ovf_q;
		if (!failed_q) begin
			case (phase_q)
				brhp_pkg::PH_PREFIX: begin
					if (byte_s1 == brhp_pkg::prefix_char(prefix_idx_q)) begin
						prefix_idx_d = prefix_idx_q + 3'd1;
						if (prefix_idx_q == 3'(brhp_pkg::PrefixN - 1)) begin
							phase_d = brhp_pkg::PH_PRE_EQ;
						end
					end else begin
						failed_d = 1'b1;
					end
				end
				brhp_pkg::PH_PRE_EQ: begin
					if (byte_s1 == brhp_pkg::ChEq) begin
						phase_d = brhp_pkg::PH_POST_EQ;
					end else if (!ws) begin
						failed_d = 1'b1;
					end
				end
				brhp_pkg::PH_POST_EQ: begin
					if (digit) begin
						phase_d      = brhp_pkg::PH_START_RUN;
						start_seen_d = 1'b1;
						start_acc_d  = start_step.acc;
						start_ovf_d  = start_step.ovf;
					end else if (byte_s1 == brhp_pkg::ChDash) begin
						phase_d = brhp_pkg::PH_POST_DASH;
					end else if (!ws) begin
						failed_d = 1'b1;
					end
				end
				brhp_pkg::PH_START_RUN: begin
					if (digit) begin
						start_acc_d = start_step.acc;
						start_ovf_d = start_step.ovf;
					end else if (byte_s1 == brhp_pkg::ChDash) begin
						phase_d = brhp_pkg::PH_POST_DASH;
					end else if (ws) begin
						phase_d = brhp_pkg::PH_PRE_DASH;
					end else begin
						failed_d = 1'b1;
					end
				end
				brhp_pkg::PH_PRE_DASH: begin
					if (byte_s1 == brhp_pkg::ChDash) begin
						phase_d = brhp_pkg::PH_POST_DASH;
					end else if (!ws) begin
						failed_d = 1'b1;
					end
				end
				brhp_pkg::PH_POST_DASH: begin
					if (digit) begin
						phase_d    = brhp_pkg::PH_END_RUN;
						end_seen_d = 1'b1;
						end_acc_d  = end_step.acc;
						end_ovf_d  = end_step.ovf;
					end else if (!ws) begin
						failed_d = 1'b1;
					end
				end
				brhp_pkg::PH_END_RUN: begin
					if (digit) begin
						end_acc_d = end_step.acc;
						end_ovf_d = end_step.ovf;
					end else begin
						failed_d = 1'b1;
					end
				end
				default: begin
					failed_d = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		fin_d.start_present = start_seen_d && !start_ovf_d;
		fin_d.end_present   = end_seen_d && !end_ovf_d;
		fin_d.start_acc     = start_acc_d;
		fin_d.end_acc       = end_acc_d;
		fin_d.ok_pre        = !failed_d
			&& (phase_d == brhp_pkg::PH_POST_DASH || phase_d == brhp_pkg::PH_END_RUN)
			&& (fin_d.start_present || fin_d.end_present);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= brhp_pkg::PH_PREFIX;
			prefix_idx_q <= '0;
			failed_q     <= 1'b0;
			start_acc_q  <= '0;
			start_seen_q <= 1'b0;
			start_ovf_q  <= 1'b0;
			end_acc_q    <= '0;
			end_seen_q   <= 1'b0;
			end_ovf_q    <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				phase_q      <= brhp_pkg::PH_PREFIX;
				prefix_idx_q <= '0;
				failed_q     <= 1'b0;
				start_acc_q  <= '0;
				start_seen_q <= 1'b0;
				start_ovf_q  <= 1'b0;
				end_acc_q    <= '0;
				end_seen_q   <= 1'b0;
				end_ovf_q    <= 1'b0;
			end else begin
				phase_q      <= phase_d;
				prefix_idx_q <= prefix_idx_d;
				failed_q     <= failed_d;
				start_acc_q  <= start_acc_d;
				start_seen_q <= start_seen_d;
				start_ovf_q  <= start_ovf_d;
				end_acc_q    <= end_acc_d;
				end_seen_q   <= end_seen_d;
				end_ovf_q    <= end_ovf_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			fin_s2 <= fin_d;
		end
	end

	// Drop the range when start exceeds end.
	assign ok_out = fin_s2.ok_pre && !(fin_s2.start_present && fin_s2.end_present
		&& (fin_s2.start_acc > fin_s2.end_acc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {5'b00000,
				(ok_out && fin_s2.end_present) ? fin_s2.end_acc : {brhp_pkg::BoundW{1'b0}},
				ok_out && fin_s2.end_present,
				(ok_out && fin_s2.start_present) ? fin_s2.start_acc : {brhp_pkg::BoundW{1'b0}},
				ok_out && fin_s2.start_present,
				ok_out};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`BRHP_ASSERT_NOW(a_fail_clears, m_tvalid && !m_tdata[0], m_tdata[135:1] == '0, "failed result carries data")
	`BRHP_ASSERT_NOW(a_ok_has_bound, m_tvalid && m_tdata[0], m_tdata[1] || m_tdata[66], "success with no bound")
	`BRHP_ASSERT_NOW(a_ok_ordered, m_tvalid && m_tdata[0] && m_tdata[1] && m_tdata[66], m_tdata[65:2] <= m_tdata[130:67], "start above end")
	`BRHP_ASSERT_NEXT(a_last_held, valid_s1 && last_s1 && !s2_free, valid_s1 && last_s1, "final beat lost while stalled")

endmodule

// ===== tb/tb_byte_range_header_parser.sv =====
// Self-checking stream testbench for the byte range header parser.
module tb_byte_range_header_parser;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          StallLimit = 1000;
	localparam int          CalmTail   = 100;
	localparam int          RandBeats  = 650;
	localparam logic [39:0] UnitText   = "bytes";
	localparam logic [63:0] BoundMax   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          LoBound    = 0;
	localparam int          HiBound    = 1;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ws;
	} hdr_beat_t;

	typedef struct packed {
		logic        parse_ok;
		logic        start_present;
		logic [63:0] start_value;
		logic        end_present;
		logic [63:0] end_value;
	} range_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         s_tlast = 1'b0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;

	hdr_beat_t     pending_beats[$];
	range_result_t expected_ranges[$];
	hdr_beat_t     next_beat;
	int            send_gap;
	int            sink_gap;
	int            idle_cycles;
	int            error_count = 0;

	brhp_pkg::phase_t hdr_phase;
	logic [2:0]       unit_pos;
	logic             parse_failed;
	logic [63:0]      bound_acc[2];
	logic             bound_seen[2];
	logic             bound_ovf[2];

	byte_range_header_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function void clear_parse();
		hdr_phase    = brhp_pkg::PH_PREFIX;
		unit_pos     = '0;
		parse_failed = 1'b0;
		for (int k = 0; k < 2; k++) begin
			bound_acc[k]  = '0;
			bound_seen[k] = 1'b0;
			bound_ovf[k]  = 1'b0;
		end
	endfunction

	function void take_digit(int k, logic [7:0] b);
		logic [63:0] d;
		d = 64'(b - brhp_pkg::ChZero);
		bound_seen[k] = 1'b1;
		if (!bound_ovf[k]) begin
			if (bound_acc[k] > (BoundMax - d) / 10) begin
				bound_ovf[k] = 1'b1;
			end else begin
				bound_acc[k] = bound_acc[k] * 10 + d;
			end
		end
	endfunction

	// Advance the parse by one beat; queue the range expected on a final beat.
	function void absorb_beat(hdr_beat_t bt);
		logic          is_digit;
		logic          is_ws;
		logic          lo_ok;
		logic          hi_ok;
		range_result_t r;
		is_digit = (bt.data >= brhp_pkg::ChZero) && (bt.data <= brhp_pkg::ChNine);
		is_ws    = bt.ws && (bt.data == brhp_pkg::ChTab || bt.data == brhp_pkg::ChSpace);
		if (!parse_failed) begin
			case (hdr_phase)
				brhp_pkg::PH_PREFIX: begin
					if (unit_pos < 3'd5 && bt.data == UnitText[39 - 8 * unit_pos -: 8]) begin
						unit_pos = unit_pos + 3'd1;
						if (unit_pos == 3'd5) hdr_phase = brhp_pkg::PH_PRE_EQ;
					end else begin
						parse_failed = 1'b1;
					end
				end
				brhp_pkg::PH_PRE_EQ: begin
					if (bt.data == brhp_pkg::ChEq) hdr_phase = brhp_pkg::PH_POST_EQ;
					else if (!is_ws) parse_failed = 1'b1;
				end
				brhp_pkg::PH_POST_EQ: begin
					if (is_digit) begin
						hdr_phase = brhp_pkg::PH_START_RUN;
						take_digit(LoBound, bt.data);
					end else if (bt.data == brhp_pkg::ChDash) hdr_phase = brhp_pkg::PH_POST_DASH;
					else if (!is_ws) parse_failed = 1'b1;
				end
				brhp_pkg::PH_START_RUN: begin
					if (is_digit) take_digit(LoBound, bt.data);
					else if (bt.data == brhp_pkg::ChDash) hdr_phase = brhp_pkg::PH_POST_DASH;
					else if (is_ws) hdr_phase = brhp_pkg::PH_PRE_DASH;
					else parse_failed = 1'b1;
				end
				brhp_pkg::PH_PRE_DASH: begin
					if (bt.data == brhp_pkg::ChDash) hdr_phase = brhp_pkg::PH_POST_DASH;
					else if (!is_ws) parse_failed = 1'b1;
				end
				brhp_pkg::PH_POST_DASH: begin
					if (is_digit) begin
						hdr_phase = brhp_pkg::PH_END_RUN;
						take_digit(HiBound, bt.data);
					end else if (!is_ws) parse_failed = 1'b1;
				end
				brhp_pkg::PH_END_RUN: begin
					if (is_digit) take_digit(HiBound, bt.data);
					else parse_failed = 1'b1;
				end
				default: parse_failed = 1'b1;
			endcase
		end
		if (bt.last) begin
			lo_ok = bound_seen[LoBound] && !bound_ovf[LoBound];
			hi_ok = bound_seen[HiBound] && !bound_ovf[HiBound];
			r = '0;
			r.parse_ok = !parse_failed
				&& (hdr_phase == brhp_pkg::PH_POST_DASH || hdr_phase == brhp_pkg::PH_END_RUN)
				&& (lo_ok || hi_ok);
			if (lo_ok && hi_ok && bound_acc[LoBound] > bound_acc[HiBound]) r.parse_ok = 1'b0;
			if (r.parse_ok) begin
				r.start_present = lo_ok;
				r.start_value   = lo_ok ? bound_acc[LoBound] : '0;
				r.end_present   = hi_ok;
				r.end_value     = hi_ok ? bound_acc[HiBound] : '0;
			end
			expected_ranges.push_back(r);
			clear_parse();
		end
	endfunction

	task report_mismatch(string msg);
		if (error_count < 50) $display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task check_range(range_result_t got);
		range_result_t want;
		if (expected_ranges.size() == 0) begin
			report_mismatch($sformatf("range result with nothing pending: %h", got));
		end else begin
			want = expected_ranges.pop_front();
			if (got.parse_ok !== want.parse_ok)
				report_mismatch($sformatf("parse_ok %b, want %b", got.parse_ok, want.parse_ok));
			if (got.start_present !== want.start_present)
				report_mismatch($sformatf("start_present %b, want %b",
					got.start_present, want.start_present));
			if (got.start_value !== want.start_value)
				report_mismatch($sformatf("start_value %0d, want %0d",
					got.start_value, want.start_value));
			if (got.end_present !== want.end_present)
				report_mismatch($sformatf("end_present %b, want %b",
					got.end_present, want.end_present));
			if (got.end_value !== want.end_value)
				report_mismatch($sformatf("end_value %0d, want %0d",
					got.end_value, want.end_value));
		end
	endtask

	task queue_byte(logic [7:0] b, logic ws, logic fin);
		hdr_beat_t bt;
		bt.data = b;
		bt.last = fin;
		bt.ws   = ws;
		pending_beats.push_back(bt);
	endtask

	task queue_text(string txt, logic ws, logic fin);
		for (int i = 0; i < txt.len(); i++) queue_byte(txt[i], ws, fin && (i == txt.len() - 1));
	endtask

	function string rand_digits();
		string s;
		int    n;
		s = "";
		case ($urandom_range(0, 9))
			0: n = 0;
			1: begin
				s = "1844674407370955161";
				n = 1;
			end
			2: n = $urandom_range(15, 25);
			default: n = $urandom_range(1, 4);
		endcase
		for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
		return s;
	endfunction

	function string rand_gap(logic ws);
		string s;
		int    n;
		s = "";
		if (ws || $urandom_range(0, 9) == 0) begin
			n = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) s = {s, ($urandom_range(0, 1) != 0) ? " " : "\t"};
		end
		return s;
	endfunction

	// Mostly well-formed ranges with random bounds; some broken, some pure noise.
	task queue_random_value();
		string      txt;
		logic [7:0] draft[$];
		logic       ws;
		logic       wobble;
		int         pos;
		ws     = $urandom_range(0, 1);
		wobble = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom_range(0, 255)));
		end else begin
			txt = {"bytes", rand_gap(ws), "=", rand_gap(ws), rand_digits(), rand_gap(ws), "-",
				rand_gap(ws), rand_digits()};
			for (int i = 0; i < txt.len(); i++) draft.push_back(txt[i]);
			if ($urandom_range(0, 4) == 0) begin
				pos = $urandom_range(0, draft.size() - 1);
				case ($urandom_range(0, 2))
					0: draft[pos] = 8'($urandom_range(0, 255));
					1: while (draft.size() > pos + 1) void'(draft.pop_back());
					default: draft.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
		foreach (draft[i])
			queue_byte(draft[i], wobble ? 1'($urandom_range(0, 1)) : ws, i == draft.size() - 1);
	endtask

	initial begin
		int directed_n;
		clear_parse();
		queue_text("bytes=0-18446744073709551615", 1'b0, 1'b1);
		queue_text("bytes=18446744073709551616-", 1'b0, 1'b1);
		queue_text("bytes=99999999999999999999-3", 1'b1, 1'b1);
		queue_text("bytes=5-", 1'b0, 1'b1);
		queue_text("bytes=-7", 1'b0, 1'b1);
		queue_text("bytes=-", 1'b0, 1'b1);
		queue_text("bytes=9-3", 1'b0, 1'b1);
		queue_text("bytes \t= 1 \t- 2", 1'b1, 1'b1);
		queue_text("bytes \t= 1 \t- 2", 1'b0, 1'b1);
		queue_text("bytes=1-2 ", 1'b1, 1'b1);
		queue_text("bytes=1", 1'b0, 1'b1);
		queue_text("Bytes=1-2", 1'b0, 1'b1);
		queue_text("bytes=1-2x!", 1'b0, 1'b1);
		queue_text("bytes=4", 1'b0, 1'b0);
		queue_text(" ", 1'b1, 1'b0);
		queue_text("-9", 1'b0, 1'b1);
		queue_text("bytes=4", 1'b1, 1'b0);
		queue_text(" -9", 1'b0, 1'b1);
		queue_byte(8'h00, 1'b0, 1'b1);
		queue_byte(8'hFF, 1'b1, 1'b1);
		directed_n = pending_beats.size();
		while (pending_beats.size() < directed_n + RandBeats) queue_random_value();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_beats.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_ranges.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tlast  <= 1'b0;
			s_tuser  <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) absorb_beat({s_tdata, s_tlast, s_tuser});
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_beats.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (pending_beats.size() > CalmTail && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 13);
					s_tvalid <= 1'b0;
				end else begin
					next_beat = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_beat.data;
					s_tlast  <= next_beat.last;
					s_tuser  <= next_beat.ws;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_range({m_tdata[0], m_tdata[1], m_tdata[65:2], m_tdata[66], m_tdata[130:67]});
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (pending_beats.size() > CalmTail && $urandom_range(0, 5) == 0) begin
				sink_gap <= $urandom_range(0, 13);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
